@@ src/dcc_pkg.sv @@
// ----------------------------------------------------------------------------
// dcc_pkg: shared types, constants and the CRC byte step
// Verdict codes, register indexes, the result record and the
// CRC-16/CCITT-FALSE byte update for the datagram frame checker.
// ----------------------------------------------------------------------------
package dcc_pkg;

	// Length counter saturation point and its width
	localparam int COUNT_LIMIT = 255;
	localparam int CNT_W       = $clog2(COUNT_LIMIT + 1);

	// CRC-16/CCITT-FALSE
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_MSB  = 16'h8000;

	// Configuration register indexes
	localparam int          CFG_IDX_W        = 2;
	localparam int          CFG_DATA_W       = 16;
	localparam logic [1:0]  REG_CMD_PREAMBLE = 2'd0;
	localparam logic [1:0]  REG_PING_PREAMBLE = 2'd1;
	localparam logic [1:0]  REG_CMD_LENGTH   = 2'd2;
	localparam logic [1:0]  REG_PING_LENGTH  = 2'd3;

	// Verdict codes
	localparam logic [2:0] VERDICT_CMD_OK        = 3'd0;
	localparam logic [2:0] VERDICT_PING_OK       = 3'd1;
	localparam logic [2:0] VERDICT_CMD_BAD_CRC   = 3'd2;
	localparam logic [2:0] VERDICT_PING_BAD_CRC  = 3'd3;
	localparam logic [2:0] VERDICT_CMD_BAD_PRE   = 3'd4;
	localparam logic [2:0] VERDICT_PING_BAD_PRE  = 3'd5;
	localparam logic [2:0] VERDICT_UNKNOWN_SIZE  = 3'd6;
	localparam logic [2:0] VERDICT_OVERSIZED     = 3'd7;

	typedef struct packed {
		logic [15:0] command_preamble;
		logic [15:0] ping_preamble;
		logic [7:0]  command_length;
		logic [7:0]  ping_length;
	} dcc_cfg_t;

	typedef struct packed {
		logic [2:0]  verdict;
		logic [7:0]  datagram_length;
		logic [15:0] computed_crc;
		logic [15:0] received_crc;
	} dcc_result_t;

	// One byte of CRC-16/CCITT-FALSE, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

@@ src/dcc_if.sv @@
// ----------------------------------------------------------------------------
// dcc_if: stream channels of the datagram frame checker
// Byte channel into the block and verdict channel out of it.
// ----------------------------------------------------------------------------
interface dcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dcc_verdict_if;
	logic        valid;
	logic        ready;
	logic [2:0]  verdict;
	logic [7:0]  datagram_length;
	logic [15:0] computed_crc;
	logic [15:0] received_crc;

	modport source (output valid, output verdict, output datagram_length,
		output computed_crc, output received_crc, input ready);
	modport sink   (input valid, input verdict, input datagram_length,
		input computed_crc, input received_crc, output ready);
endinterface

@@ src/dcc_frame_state.sv @@
// ----------------------------------------------------------------------------
// dcc_frame_state: per-datagram running state and verdict logic
// Holds CRC, length count, first word and last two bytes; advances on
// each byte and produces the verdict of the final byte.
// ----------------------------------------------------------------------------
module dcc_frame_state (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	input  dcc_pkg::dcc_cfg_t   cfg,
	output dcc_pkg::dcc_result_t result
);
	import dcc_pkg::*;

	logic [15:0]      crc_q;
	logic [CNT_W-1:0] count_q;
	logic [15:0]      trailing_q;
	logic [15:0]      leading_q;

	logic [15:0]      crc_n;
	logic [CNT_W-1:0] count_n;
	logic [15:0]      trailing_n;
	logic [15:0]      leading_n;
	logic [15:0]      len16;

	// Next state: the byte leaving the two-byte window joins the CRC
	always_comb begin
		crc_n      = (count_q >= CNT_W'(2)) ? crc_byte(crc_q, trailing_q[7:0]) : crc_q;
		leading_n  = leading_q;
		if (count_q == '0) begin
			leading_n[7:0] = data_byte;
		end else if (count_q == CNT_W'(1)) begin
			leading_n[15:8] = data_byte;
		end
		trailing_n = {data_byte, trailing_q[15:8]};
		count_n    = (count_q < CNT_W'(COUNT_LIMIT)) ? count_q + CNT_W'(1) : count_q;
	end

	// Classify the datagram as it stands after this byte
	always_comb begin
		len16 = 16'(count_n);
		if (len16 > 16'(cfg.command_length)) begin
			result.verdict = VERDICT_OVERSIZED;
		end else if (len16 == 16'(cfg.command_length)) begin
			if (leading_n != cfg.command_preamble) begin
				result.verdict = VERDICT_CMD_BAD_PRE;
			end else if (crc_n != trailing_n) begin
				result.verdict = VERDICT_CMD_BAD_CRC;
			end else begin
				result.verdict = VERDICT_CMD_OK;
			end
		end else if (len16 == 16'(cfg.ping_length)) begin
			if (leading_n != cfg.ping_preamble) begin
				result.verdict = VERDICT_PING_BAD_PRE;
			end else if (crc_n != trailing_n) begin
				result.verdict = VERDICT_PING_BAD_CRC;
			end else begin
				result.verdict = VERDICT_PING_OK;
			end
		end else begin
			result.verdict = VERDICT_UNKNOWN_SIZE;
		end
		result.datagram_length = (len16 > 16'd255) ? 8'hFF : len16[7:0];
		result.computed_crc    = crc_n;
		result.received_crc    = trailing_n;
	end

	// Advance on each byte; clear for the next datagram after the final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_INIT;
			count_q    <= '0;
			trailing_q <= '0;
			leading_q  <= '0;
		end else if (step) begin
			if (last_byte) begin
				crc_q      <= CRC_INIT;
				count_q    <= '0;
				trailing_q <= '0;
				leading_q  <= '0;
			end else begin
				crc_q      <= crc_n;
				count_q    <= count_n;
				trailing_q <= trailing_n;
				leading_q  <= leading_n;
			end
		end
	end

endmodule

@@ src/datagram_crc_classifier_unit.sv @@
// ----------------------------------------------------------------------------
// datagram_crc_classifier_unit: received datagram frame check
// Checks CRC-16/CCITT-FALSE, preamble and length of each datagram and
// reports one verdict per datagram.
// ----------------------------------------------------------------------------
// Bytes arrive one per beat on rx, the final byte of a datagram flagged by
// last_byte. Each accepted beat is registered in the input register, then the
// CRC byte update and compare logic advances the frame state; the final byte
// loads a verdict into the report output register. The block takes one byte
// per cycle; it stalls only when a new verdict is ready while the previous
// one is still waiting on report. The CRC covers every byte but the last two,
// which are read little-endian as the received CRC; the first two bytes form
// the preamble. Registers (cfg_index): 0 command preamble, 1 ping preamble,
// 2 command length (also the oversize limit), 3 ping length; write them
// while no datagram is in flight.
module datagram_crc_classifier_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	dcc_byte_if.sink                           rx,
	dcc_verdict_if.source                      report,
	input  logic                               cfg_we,
	input  logic [dcc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dcc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import dcc_pkg::*;

	dcc_cfg_t    cfg_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        go_s1;

	dcc_result_t result;
	dcc_result_t result_q;
	logic        out_valid_q;
	logic        out_free;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.command_preamble <= 16'd0;
			cfg_q.ping_preamble    <= 16'd0;
			cfg_q.command_length   <= 8'd25;
			cfg_q.ping_length      <= 8'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CMD_PREAMBLE:  cfg_q.command_preamble <= cfg_data;
				REG_PING_PREAMBLE: cfg_q.ping_preamble    <= cfg_data;
				REG_CMD_LENGTH:    cfg_q.command_length   <= cfg_data[7:0];
				REG_PING_LENGTH:   cfg_q.ping_length      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Stage 1 moves on unless it holds a final byte and the output is full
	assign out_free = !out_valid_q || report.ready;
	assign go_s1    = valid_s1 && (!last_s1 || out_free);
	assign rx.ready = !valid_s1 || go_s1;

	// Input register: capture each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.data_byte;
			last_s1 <= rx.last_byte;
		end
	end

	dcc_frame_state u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (go_s1),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.cfg       (cfg_q),
		.result    (result)
	);

	// Output register: load a verdict, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			result_q <= result;
		end
	end

	assign report.valid           = out_valid_q;
	assign report.verdict         = result_q.verdict;
	assign report.datagram_length = result_q.datagram_length;
	assign report.computed_crc    = result_q.computed_crc;
	assign report.received_crc    = result_q.received_crc;

endmodule

@@ bench/datagram_crc_classifier_unit_tb.sv @@
// ----------------------------------------------------------------------------
// datagram_crc_classifier_unit_tb: self-checking bench for the frame checker
// Streams datagrams through the byte channel under several register settings,
// predicts each verdict from its own CRC-16/CCITT-FALSE frame model and checks
// every reported beat field by field, with random gaps on both channels.
// ----------------------------------------------------------------------------
module datagram_crc_classifier_unit_tb;

	import dcc_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} rx_beat_t;

	// How the two final bytes of a generated datagram are filled
	typedef enum int {TAIL_RANDOM, TAIL_GOOD, TAIL_BAD} tail_e;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	dcc_byte_if    rx_ch ();
	dcc_verdict_if rep_ch ();

	datagram_crc_classifier_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.report    (rep_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Bytes waiting for the driver and verdicts waiting for the monitor
	rx_beat_t    pending_bytes[$];
	dcc_result_t awaited_verdicts[$];
	rx_beat_t    next_beat;

	// Register copies and frame state of the bench-side checker
	logic [15:0] cfg_cmd_pre;
	logic [15:0] cfg_ping_pre;
	logic [7:0]  cfg_cmd_len;
	logic [7:0]  cfg_ping_len;
	logic [15:0] frame_crc;
	logic [15:0] frame_tail;
	logic [15:0] frame_head;
	int          frame_count;

	bit          gaps_on;
	int          errors;
	int          bytes_accepted;
	int          verdicts_checked;
	logic [7:0]  verdicts_seen;

	always #1 clk = ~clk;

	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] r;
		r = crc ^ {b, 8'h00};
		repeat (8) r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
		return r;
	endfunction

	// Advance the frame model by one accepted byte; queue a verdict at the end
	function automatic void absorb_byte(input logic [7:0] b, input logic last);
		dcc_result_t res;
		if (frame_count >= 2)
			frame_crc = crc16_step(frame_crc, frame_tail[7:0]);
		if (frame_count == 0)
			frame_head[7:0] = b;
		else if (frame_count == 1)
			frame_head[15:8] = b;
		frame_tail = {b, frame_tail[15:8]};
		if (frame_count < COUNT_LIMIT)
			frame_count++;
		if (last) begin
			if (frame_count > cfg_cmd_len)
				res.verdict = VERDICT_OVERSIZED;
			else if (frame_count == cfg_cmd_len)
				res.verdict = (frame_head != cfg_cmd_pre) ? VERDICT_CMD_BAD_PRE :
					(frame_crc != frame_tail) ? VERDICT_CMD_BAD_CRC : VERDICT_CMD_OK;
			else if (frame_count == cfg_ping_len)
				res.verdict = (frame_head != cfg_ping_pre) ? VERDICT_PING_BAD_PRE :
					(frame_crc != frame_tail) ? VERDICT_PING_BAD_CRC : VERDICT_PING_OK;
			else
				res.verdict = VERDICT_UNKNOWN_SIZE;
			res.datagram_length = (frame_count > 255) ? 8'd255 : 8'(frame_count);
			res.computed_crc    = frame_crc;
			res.received_crc    = frame_tail;
			awaited_verdicts.push_back(res);
			frame_crc   = CRC_INIT;
			frame_tail  = '0;
			frame_head  = '0;
			frame_count = 0;
		end
	endfunction

	function automatic void push_beat(input logic [7:0] b, input logic last);
		rx_beat_t beat;
		beat.data = b;
		beat.last = last;
		pending_bytes.push_back(beat);
	endfunction

	// Build one datagram: random body, optional preamble, chosen CRC tail
	function automatic void queue_datagram(input int len, input bit set_pre,
		input logic [15:0] pre, input tail_e tail);
		logic [7:0]  fb[$];
		logic [15:0] crc;
		fb = {};
		for (int i = 0; i < len; i++)
			fb.push_back(8'($urandom));
		if (set_pre && len >= 2) begin
			fb[0] = pre[7:0];
			fb[1] = pre[15:8];
		end
		crc = CRC_INIT;
		for (int i = 0; i < len - 2; i++)
			crc = crc16_step(crc, fb[i]);
		if (tail != TAIL_RANDOM) begin
			if (tail == TAIL_BAD)
				crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
			if (len >= 2)
				fb[len-2] = crc[7:0];
			if (len >= 1)
				fb[len-1] = crc[15:8];
		end
		foreach (fb[i])
			push_beat(fb[i], i == len - 1);
	endfunction

	// Hold until every byte is taken and every verdict is back, then settle
	task automatic wait_drain();
		while (pending_bytes.size() != 0 || rx_ch.valid || awaited_verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CMD_PREAMBLE:  cfg_cmd_pre  = value;
			REG_PING_PREAMBLE: cfg_ping_pre = value;
			REG_CMD_LENGTH:    cfg_cmd_len  = value[7:0];
			REG_PING_LENGTH:   cfg_ping_len = value[7:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [15:0] cmd_pre, input logic [15:0] ping_pre,
		input logic [7:0] cmd_len, input logic [7:0] ping_len);
		wait_drain();
		write_reg(REG_CMD_PREAMBLE, cmd_pre);
		write_reg(REG_PING_PREAMBLE, ping_pre);
		write_reg(REG_CMD_LENGTH, {8'h00, cmd_len});
		write_reg(REG_PING_LENGTH, {8'h00, ping_len});
	endtask

	// Mostly well-formed command and ping datagrams, some broken ones and noise
	task automatic random_frames(input int budget, input int min_frames, input int max_noise);
		int pushed;
		int frames;
		int pick;
		int len;
		bit to_cmd;
		pushed = 0;
		frames = 0;
		while (pushed < budget || frames < min_frames) begin
			pick   = $urandom_range(0, 99);
			to_cmd = $urandom_range(0, 1);
			len    = to_cmd ? int'(cfg_cmd_len) : int'(cfg_ping_len);
			if (len < 1)
				len = 1;
			if (pick < 35) begin
				len = (cfg_cmd_len < 1) ? 1 : int'(cfg_cmd_len);
				queue_datagram(len, 1'b1, cfg_cmd_pre, TAIL_GOOD);
			end else if (pick < 65) begin
				len = (cfg_ping_len < 1) ? 1 : int'(cfg_ping_len);
				queue_datagram(len, 1'b1, cfg_ping_pre, TAIL_GOOD);
			end else if (pick < 75) begin
				queue_datagram(len, 1'b1, to_cmd ? cfg_cmd_pre : cfg_ping_pre, TAIL_BAD);
			end else if (pick < 85) begin
				queue_datagram(len, 1'b1, (to_cmd ? cfg_cmd_pre : cfg_ping_pre) ^
					16'($urandom_range(1, 16'hFFFF)), TAIL_GOOD);
			end else begin
				len = $urandom_range(1, max_noise);
				queue_datagram(len, 1'b0, 16'h0000, TAIL_RANDOM);
			end
			pushed += len;
			frames++;
			// let the sender run dry once per phase
			if (frames == min_frames / 2)
				wait_drain();
		end
	endtask

	// Driver: offer queued bytes, model each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid     <= 1'b0;
			rx_ch.data_byte <= 8'h00;
			rx_ch.last_byte <= 1'b0;
		end else begin
			if (rx_ch.valid && rx_ch.ready) begin
				absorb_byte(rx_ch.data_byte, rx_ch.last_byte);
				bytes_accepted++;
			end
			if (!rx_ch.valid || rx_ch.ready) begin
				if (pending_bytes.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 6)) begin
					next_beat = pending_bytes.pop_front();
					rx_ch.valid     <= 1'b1;
					rx_ch.data_byte <= next_beat.data;
					rx_ch.last_byte <= next_beat.last;
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random, compare each verdict beat with the oldest one due
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_ch.ready <= 1'b0;
		end else begin
			rep_ch.ready <= !(gaps_on && $urandom_range(0, 99) < 6);
			if (rep_ch.valid && rep_ch.ready) begin
				if (awaited_verdicts.size() == 0) begin
					errors++;
					$display("%0t: unexpected verdict beat: expected none, actual %0d",
						$time, rep_ch.verdict);
				end else begin
					if (rep_ch.verdict !== awaited_verdicts[0].verdict) begin
						errors++;
						$display("%0t: verdict: expected %0d, actual %0d", $time,
							awaited_verdicts[0].verdict, rep_ch.verdict);
					end
					if (rep_ch.datagram_length !== awaited_verdicts[0].datagram_length) begin
						errors++;
						$display("%0t: datagram_length: expected %0d, actual %0d", $time,
							awaited_verdicts[0].datagram_length, rep_ch.datagram_length);
					end
					if (rep_ch.computed_crc !== awaited_verdicts[0].computed_crc) begin
						errors++;
						$display("%0t: computed_crc: expected %h, actual %h", $time,
							awaited_verdicts[0].computed_crc, rep_ch.computed_crc);
					end
					if (rep_ch.received_crc !== awaited_verdicts[0].received_crc) begin
						errors++;
						$display("%0t: received_crc: expected %h, actual %h", $time,
							awaited_verdicts[0].received_crc, rep_ch.received_crc);
					end
					verdicts_seen[awaited_verdicts[0].verdict] = 1'b1;
					void'(awaited_verdicts.pop_front());
					verdicts_checked++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		#400000;
		$display("[datagram_crc_classifier_unit] ERROR");
		$finish;
	end

	initial begin
		int wait_cycles;
		clk              = 1'b0;
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		rx_ch.valid      = 1'b0;
		rx_ch.data_byte  = 8'h00;
		rx_ch.last_byte  = 1'b0;
		rep_ch.ready     = 1'b0;
		gaps_on          = 1'b1;
		errors           = 0;
		bytes_accepted   = 0;
		verdicts_checked = 0;
		verdicts_seen    = '0;
		cfg_cmd_pre      = 16'h0000;
		cfg_ping_pre     = 16'h0000;
		cfg_cmd_len      = 8'd25;
		cfg_ping_len     = 8'd16;
		frame_crc        = CRC_INIT;
		frame_tail       = '0;
		frame_head       = '0;
		frame_count      = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset register values: command and ping accepted with zero preamble
		queue_datagram(25, 1'b1, 16'h0000, TAIL_GOOD);
		queue_datagram(16, 1'b1, 16'h0000, TAIL_GOOD);

		// Directed: every verdict path but a good ping, short datagrams, extreme byte values
		set_regs(16'hA55A, 16'h0FF0, 8'd4, 8'd3);
		queue_datagram(4, 1'b1, 16'hA55A, TAIL_GOOD);
		queue_datagram(4, 1'b1, 16'hA55A, TAIL_BAD);
		queue_datagram(4, 1'b1, 16'h5AA5, TAIL_GOOD);
		queue_datagram(3, 1'b1, 16'h1234, TAIL_RANDOM);
		queue_datagram(3, 1'b1, 16'h0FF0, TAIL_RANDOM);
		push_beat(8'h80, 1'b1);
		push_beat(8'hFF, 1'b0);
		push_beat(8'h00, 1'b1);
		push_beat(8'h00, 1'b0);
		push_beat(8'hFF, 1'b0);
		push_beat(8'h00, 1'b0);
		push_beat(8'hFF, 1'b0);
		push_beat(8'hFF, 1'b1);

		// Typical lengths with random preambles
		set_regs(16'($urandom), 16'($urandom), 8'd25, 8'd16);
		random_frames(60, 4, 30);

		// Extreme preambles and a three-byte ping length
		set_regs(16'hFFFF, 16'h0000, 8'd12, 8'd3);
		random_frames(40, 6, 16);

		// Equal lengths: command checks take precedence
		set_regs(16'($urandom), 16'($urandom), 8'd10, 8'd10);
		random_frames(40, 5, 14);

		// Out-of-range lengths, saturated counter, two-byte ping
		set_regs(16'($urandom), 16'hFFFF, 8'd255, 8'd2);
		queue_datagram(256, 1'b1, cfg_cmd_pre, TAIL_GOOD);
		queue_datagram(2, 1'b1, 16'hFFFF, TAIL_RANDOM);
		queue_datagram(2, 1'b0, 16'h0000, TAIL_RANDOM);
		queue_datagram(1, 1'b0, 16'h0000, TAIL_RANDOM);
		queue_datagram(7, 1'b0, 16'h0000, TAIL_RANDOM);

		// Back-to-back stretch with no gaps on either side
		set_regs(16'($urandom), 16'($urandom), 8'd8, 8'd5);
		gaps_on = 1'b0;
		random_frames(50, 8, 12);
		wait_drain();
		gaps_on = 1'b1;

		// Drain and settle
		wait_cycles = 0;
		while ((pending_bytes.size() != 0 || rx_ch.valid || awaited_verdicts.size() != 0)
			&& wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		if (wait_cycles >= 20000) begin
			$display("[datagram_crc_classifier_unit] ERROR");
			$finish;
		end else begin
			repeat (10) @(posedge clk);
			$display("Ran %0d bytes into %0d checked verdicts over seven register settings.",
				bytes_accepted, verdicts_checked);
			$display("Verdict codes reached (bit per code, 7..0): %b", verdicts_seen);
			if (errors == 0)
				$display("[datagram_crc_classifier_unit] OK");
			else
				$display("[datagram_crc_classifier_unit] ERROR");
			$finish;
		end
	end

endmodule

@@ files.f @@
src/dcc_pkg.sv
src/dcc_if.sv
src/dcc_frame_state.sv
src/datagram_crc_classifier_unit.sv
bench/datagram_crc_classifier_unit_tb.sv
